// ===== src/lwf_pkg.sv =====
// Shared types and constants for the line / wall following PD drive unit.
// Holds register indexes, reset values, drive mode codes and the
// configuration and control structs. No dependencies.
package lwf_pkg;

  // Field widths fixed by the register map and result format
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_INDEX_W   = 3;
  localparam int READING_CFG_W = 10;
  localparam int BASE_W        = 4;
  localparam int GAIN_W        = 8;
  localparam int SUM_W         = 4;
  localparam int SPEED_W       = 13;
  localparam int MODE_W        = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_THRESHOLD     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_TARGET        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_NEAR_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_CLEAR_READING = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_BASE_SPEED    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_BASE_SPEED    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_P_GAIN        = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_D_GAIN        = 3'd7;

  // Register reset values
  localparam logic [READING_CFG_W-1:0] RST_LINE_THRESHOLD     = 10'd700;
  localparam logic [READING_CFG_W-1:0] RST_WALL_TARGET        = 10'd750;
  localparam logic [READING_CFG_W-1:0] RST_WALL_NEAR_LIMIT    = 10'd950;
  localparam logic [READING_CFG_W-1:0] RST_WALL_CLEAR_READING = 10'd1000;
  localparam logic [BASE_W-1:0]        RST_LINE_BASE_SPEED    = 4'd3;
  localparam logic [BASE_W-1:0]        RST_WALL_BASE_SPEED    = 4'd2;
  localparam logic [GAIN_W-1:0]        RST_LINE_P_GAIN        = 8'd25;
  localparam logic [GAIN_W-1:0]        RST_LINE_D_GAIN        = 8'd45;

  // Drive mode codes
  localparam logic [MODE_W-1:0] MODE_LINE       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT_WALL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT_WALL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STRAIGHT   = 2'd3;

  typedef struct packed {
    logic [READING_CFG_W-1:0] line_threshold;
    logic [READING_CFG_W-1:0] wall_target;
    logic [READING_CFG_W-1:0] wall_near_limit;
    logic [READING_CFG_W-1:0] wall_clear_reading;
    logic [BASE_W-1:0]        line_base_speed;
    logic [BASE_W-1:0]        wall_base_speed;
    logic [GAIN_W-1:0]        line_p_gain;
    logic [GAIN_W-1:0]        line_d_gain;
  } lwf_cfg_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              neg;
    logic [BASE_W-1:0] base;
  } lwf_ctrl_t;

endpackage

// ===== src/lwf_fifo.sv =====
// Small synchronous queue used between the front end, the back end and the ports.
// Depends on nothing; DEPTH must be a power of two.
module lwf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Store payload; no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/lwf_front.sv =====
// Front end: classifies a sensor sample into a drive mode, forms the PD
// numerator magnitude and keeps the previous errors. Depends on lwf_pkg.
module lwf_front #(
  parameter int SENSOR_BITS = 10,
  parameter int XW          = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [SENSOR_BITS-1:0] line_far_left,
  input  logic [SENSOR_BITS-1:0] line_mid_left,
  input  logic [SENSOR_BITS-1:0] line_inner_left,
  input  logic [SENSOR_BITS-1:0] line_inner_right,
  input  logic [SENSOR_BITS-1:0] line_mid_right,
  input  logic [SENSOR_BITS-1:0] line_far_right,
  input  logic [SENSOR_BITS-1:0] right_distance,
  input  logic [SENSOR_BITS-1:0] left_distance,
  input  lwf_pkg::lwf_cfg_t      cfg,
  output lwf_pkg::lwf_ctrl_t     ctrl,
  output logic [XW-1:0]          x
);
  import lwf_pkg::*;

  localparam int SW = (SENSOR_BITS > READING_CFG_W) ? SENSOR_BITS : READING_CFG_W;
  localparam int OW = SW + 1;
  localparam int VW = OW + 2;
  localparam int NW = 14;

  logic [5:0]              hit;
  logic [SW-1:0]           thr;
  logic [SW-1:0]           rd;
  logic [SW-1:0]           ld;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] prev_line_sum;
  logic signed [SUM_W:0]   diff;
  logic signed [NW-1:0]    line_num;
  logic [NW-2:0]           line_mag;
  logic signed [OW-1:0]    roff;
  logic signed [OW-1:0]    loff;
  logic signed [OW-1:0]    prev_right_offset;
  logic signed [OW-1:0]    prev_left_offset;
  logic signed [VW-1:0]    rv;
  logic signed [VW-1:0]    lv;
  logic [VW-2:0]           rv_mag;
  logic [VW-2:0]           lv_mag;
  logic                    any_line;
  logic                    right_wall;
  logic                    left_wall;

  // Line sensors at or below the threshold see the line
  assign thr    = SW'(cfg.line_threshold);
  assign hit[0] = SW'(line_far_left) <= thr;
  assign hit[1] = SW'(line_mid_left) <= thr;
  assign hit[2] = SW'(line_inner_left) <= thr;
  assign hit[3] = SW'(line_inner_right) <= thr;
  assign hit[4] = SW'(line_mid_right) <= thr;
  assign hit[5] = SW'(line_far_right) <= thr;
  assign any_line = |hit;

  // Weighted line error, 3 2 1 -1 -2 -3
  always_comb begin
    sum = '0;
    if (hit[0]) sum = sum + 4'sd3;
    if (hit[1]) sum = sum + 4'sd2;
    if (hit[2]) sum = sum + 4'sd1;
    if (hit[3]) sum = sum - 4'sd1;
    if (hit[4]) sum = sum - 4'sd2;
    if (hit[5]) sum = sum - 4'sd3;
  end

  // Line PD numerator: P*S + D*(S - previous S)
  assign diff     = (SUM_W+1)'(sum) - (SUM_W+1)'(prev_line_sum);
  assign line_num = NW'($signed({1'b0, cfg.line_p_gain})) * NW'(sum)
                  + NW'($signed({1'b0, cfg.line_d_gain})) * NW'(diff);
  assign line_mag = line_num[NW-1] ? (NW-1)'(-line_num) : (NW-1)'(line_num);

  // Wall offsets and their PD numerators 2*o - previous o
  assign rd     = SW'(right_distance);
  assign ld     = SW'(left_distance);
  assign roff   = $signed({1'b0, rd}) - $signed({1'b0, SW'(cfg.wall_target)});
  assign loff   = $signed({1'b0, ld}) - $signed({1'b0, SW'(cfg.wall_target)});
  assign rv     = (VW'(roff) <<< 1) - VW'(prev_right_offset);
  assign lv     = (VW'(loff) <<< 1) - VW'(prev_left_offset);
  assign rv_mag = rv[VW-1] ? (VW-1)'(-rv) : (VW-1)'(rv);
  assign lv_mag = lv[VW-1] ? (VW-1)'(-lv) : (VW-1)'(lv);

  assign right_wall = (rd < SW'(cfg.wall_near_limit)) && (ld == SW'(cfg.wall_clear_reading));
  assign left_wall  = (rd == SW'(cfg.wall_clear_reading)) && (ld < SW'(cfg.wall_near_limit));

  // Pick the mode; the numerator carries its rounding offset (7 for /15, 2 for /5)
  always_comb begin
    if (any_line) begin
      ctrl.mode = MODE_LINE;
      ctrl.neg  = line_num[NW-1];
      ctrl.base = cfg.line_base_speed;
      x         = XW'({line_mag, 7'd7});
    end else if (right_wall) begin
      ctrl.mode = MODE_RIGHT_WALL;
      ctrl.neg  = rv[VW-1];
      ctrl.base = cfg.wall_base_speed;
      x         = XW'({rv_mag, 6'd2});
    end else if (left_wall) begin
      ctrl.mode = MODE_LEFT_WALL;
      ctrl.neg  = lv[VW-1];
      ctrl.base = cfg.wall_base_speed;
      x         = XW'({lv_mag, 6'd2});
    end else begin
      ctrl.mode = MODE_STRAIGHT;
      ctrl.neg  = 1'b0;
      ctrl.base = cfg.wall_base_speed;
      x         = '0;
    end
  end

  // Hold the previous errors; updated on every accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_line_sum     <= '0;
      prev_right_offset <= '0;
      prev_left_offset  <= '0;
    end else if (accept) begin
      prev_line_sum     <= sum;
      prev_right_offset <= roff;
      prev_left_offset  <= loff;
    end
  end

endmodule

// ===== src/lwf_back.sv =====
// Back end: divides the PD numerator by a constant via a reciprocal
// multiply, applies base speed, sign and saturation. Depends on lwf_pkg.
module lwf_back #(
  parameter int SPEED_LIMIT = 10,
  parameter int XW          = 20,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  lwf_pkg::lwf_ctrl_t             head_ctrl,
  input  logic [XW-1:0]                  head_x,
  output logic                           head_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output logic [lwf_pkg::MODE_W-1:0]     out_mode,
  output logic signed [lwf_pkg::SPEED_W-1:0] out_left,
  output logic signed [lwf_pkg::SPEED_W-1:0] out_right
);
  import lwf_pkg::*;

  localparam int OCW     = $clog2(OUT_DEPTH+1);
  localparam int PW      = 2 * XW + 1;
  localparam int CW      = XW + 3;
  localparam int LIM_RAW = SPEED_LIMIT * 256;
  localparam int LIM     = (LIM_RAW > 4095) ? 4095 : LIM_RAW;
  // Reciprocals exact for any numerator below 2**XW
  localparam logic [XW:0] K5  = (XW+1)'(((64'd1 << (XW + 3)) + 64'd4) / 64'd5);
  localparam logic [XW:0] K15 = (XW+1)'(((64'd1 << (XW + 4)) + 64'd14) / 64'd15);
  localparam logic signed [CW-1:0] LIM_HI = CW'(LIM);
  localparam logic signed [CW-1:0] LIM_LO = CW'(-LIM);

  logic                   r1_valid;
  lwf_ctrl_t              r1_ctrl;
  logic [PW-1:0]          prod;
  logic [XW-1:0]          q;
  logic signed [CW-1:0]   delta_mag;
  logic signed [CW-1:0]   delta;
  logic signed [CW-1:0]   base_s;
  logic signed [CW-1:0]   left_raw;
  logic signed [CW-1:0]   right_raw;

  function automatic logic signed [SPEED_W-1:0] sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > LIM_HI) begin
      r = LIM_HI;
    end else if (v < LIM_LO) begin
      r = LIM_LO;
    end else begin
      r = v;
    end
    return SPEED_W'(r);
  endfunction

  // Take the next item only when the result queue has room for it
  assign head_pop = head_valid &&
                    ((OCW+1)'(out_count) + (OCW+1)'(r1_valid) < (OCW+1)'(OUT_DEPTH));

  // Reciprocal multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else begin
      r1_valid <= head_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      r1_ctrl <= head_ctrl;
      prod    <= PW'(head_x) * PW'((head_ctrl.mode == MODE_LINE) ? K15 : K5);
    end
  end

  // Finish: quotient, sign, wheel split and saturation
  assign q         = (r1_ctrl.mode == MODE_LINE) ? XW'(prod >> (XW + 4))
                                                 : XW'(prod >> (XW + 3));
  assign delta_mag = $signed({3'b000, q});
  assign delta     = r1_ctrl.neg ? -delta_mag : delta_mag;
  assign base_s    = $signed(CW'({r1_ctrl.base, 8'd0}));

  always_comb begin
    if (r1_ctrl.mode == MODE_RIGHT_WALL) begin
      left_raw  = base_s + delta;
      right_raw = base_s - delta;
    end else begin
      left_raw  = base_s - delta;
      right_raw = base_s + delta;
    end
  end

  assign out_push  = r1_valid;
  assign out_mode  = r1_ctrl.mode;
  assign out_left  = sat(left_raw);
  assign out_right = sat(right_raw);

endmodule

// ===== src/line_wall_follow_pd_drive_unit.sv =====
// Top level of the line / wall following PD drive unit.
// Depends on lwf_pkg, lwf_front, lwf_fifo and lwf_back.
//
// Usage:
//   Input channel: drive the eight sensor readings and raise push; the
//   sample is taken at a clock edge with push high and full low.
//   Result channel: while empty is low the oldest wheel-speed pair and
//   drive mode sit on left_speed, right_speed and drive_mode; raise pop
//   to take it. One result per sample, in order.
//   Configuration: cfg_write with cfg_index and cfg_data writes one
//   register at the clock edge; write only while no sample is in flight.
// Path: a taken sample passes from the front end into a 4-entry queue,
//   one reciprocal-multiply stage, then a 4-entry result queue, and shows
//   on the result ports once it is at the head of that result queue.
// Throughput: one sample per cycle, sustained while pop keeps up.
// Stall: when pop stays low the result queue fills, the back end holds its
//   items in the middle queue, and full rises once that queue is also full.
// Reset (rst, synchronous): queues empty, registers to their defaults,
//   previous line and wall errors to zero.
module line_wall_follow_pd_drive_unit #(
  parameter int SPEED_LIMIT = 10,
  parameter int SENSOR_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [SENSOR_BITS-1:0]             line_far_left,
  input  logic [SENSOR_BITS-1:0]             line_mid_left,
  input  logic [SENSOR_BITS-1:0]             line_inner_left,
  input  logic [SENSOR_BITS-1:0]             line_inner_right,
  input  logic [SENSOR_BITS-1:0]             line_mid_right,
  input  logic [SENSOR_BITS-1:0]             line_far_right,
  input  logic [SENSOR_BITS-1:0]             right_distance,
  input  logic [SENSOR_BITS-1:0]             left_distance,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [lwf_pkg::SPEED_W-1:0] left_speed,
  output logic signed [lwf_pkg::SPEED_W-1:0] right_speed,
  output logic [lwf_pkg::MODE_W-1:0]         drive_mode,
  input  logic                               cfg_write,
  input  logic [lwf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lwf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lwf_pkg::*;

  localparam int SW        = (SENSOR_BITS > READING_CFG_W) ? SENSOR_BITS : READING_CFG_W;
  localparam int XW        = (SW + 8 > 20) ? SW + 8 : 20;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int MID_W     = $bits(lwf_ctrl_t) + XW;
  localparam int OUT_W     = MODE_W + 2 * SPEED_W;
  localparam int OCW       = $clog2(OUT_DEPTH+1);

  lwf_cfg_t                  cfg;
  lwf_ctrl_t                 front_ctrl;
  logic [XW-1:0]             front_x;
  logic                      accept;
  logic [MID_W-1:0]          mid_dout;
  logic                      mid_empty;
  lwf_ctrl_t                 head_ctrl;
  logic [XW-1:0]             head_x;
  logic                      head_pop;
  logic [OCW-1:0]            out_count;
  logic                      out_push;
  logic [MODE_W-1:0]         out_mode;
  logic signed [SPEED_W-1:0] out_left;
  logic signed [SPEED_W-1:0] out_right;
  logic [OUT_W-1:0]          out_dout;

  assign accept = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_threshold     <= RST_LINE_THRESHOLD;
      cfg.wall_target        <= RST_WALL_TARGET;
      cfg.wall_near_limit    <= RST_WALL_NEAR_LIMIT;
      cfg.wall_clear_reading <= RST_WALL_CLEAR_READING;
      cfg.line_base_speed    <= RST_LINE_BASE_SPEED;
      cfg.wall_base_speed    <= RST_WALL_BASE_SPEED;
      cfg.line_p_gain        <= RST_LINE_P_GAIN;
      cfg.line_d_gain        <= RST_LINE_D_GAIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINE_THRESHOLD:     cfg.line_threshold     <= cfg_data;
        REG_WALL_TARGET:        cfg.wall_target        <= cfg_data;
        REG_WALL_NEAR_LIMIT:    cfg.wall_near_limit    <= cfg_data;
        REG_WALL_CLEAR_READING: cfg.wall_clear_reading <= cfg_data;
        REG_LINE_BASE_SPEED:    cfg.line_base_speed    <= cfg_data[BASE_W-1:0];
        REG_WALL_BASE_SPEED:    cfg.wall_base_speed    <= cfg_data[BASE_W-1:0];
        REG_LINE_P_GAIN:        cfg.line_p_gain        <= cfg_data[GAIN_W-1:0];
        REG_LINE_D_GAIN:        cfg.line_d_gain        <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lwf_front #(
    .SENSOR_BITS(SENSOR_BITS),
    .XW         (XW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .line_far_left   (line_far_left),
    .line_mid_left   (line_mid_left),
    .line_inner_left (line_inner_left),
    .line_inner_right(line_inner_right),
    .line_mid_right  (line_mid_right),
    .line_far_right  (line_far_right),
    .right_distance  (right_distance),
    .left_distance   (left_distance),
    .cfg             (cfg),
    .ctrl            (front_ctrl),
    .x               (front_x)
  );

  // Queue between classification and arithmetic
  lwf_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({front_ctrl, front_x}),
    .full (full),
    .pop  (head_pop),
    .dout (mid_dout),
    .empty(mid_empty),
    .count()
  );

  assign {head_ctrl, head_x} = mid_dout;

  lwf_back #(
    .SPEED_LIMIT(SPEED_LIMIT),
    .XW         (XW),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(!mid_empty),
    .head_ctrl (head_ctrl),
    .head_x    (head_x),
    .head_pop  (head_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_mode  (out_mode),
    .out_left  (out_left),
    .out_right (out_right)
  );

  // Result queue facing the consumer
  lwf_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .din  ({out_mode, out_left, out_right}),
    .full (),
    .pop  (pop),
    .dout (out_dout),
    .empty(empty),
    .count(out_count)
  );

  assign {drive_mode, left_speed, right_speed} = out_dout;

endmodule

// ===== src/lwf_checker.sv =====
// Port-level checks for the line / wall following PD drive unit, bound to
// the top level. Depends on lwf_pkg.
module lwf_checker #(
  parameter int SPEED_LIMIT = 10
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [lwf_pkg::SPEED_W-1:0] left_speed,
  input logic signed [lwf_pkg::SPEED_W-1:0] right_speed,
  input logic [lwf_pkg::MODE_W-1:0]         drive_mode
);
  import lwf_pkg::*;

  localparam int LIM_RAW = SPEED_LIMIT * 256;
  localparam int LIM     = (LIM_RAW > 4095) ? 4095 : LIM_RAW;
  localparam logic signed [SPEED_W-1:0] LIM_HI = SPEED_W'(LIM);
  localparam logic signed [SPEED_W-1:0] LIM_LO = SPEED_W'(-LIM);

  // Reset leaves both queues empty
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // Waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(left_speed) && $stable(right_speed)
                          && $stable(drive_mode)))
    else $error("waiting result changed before pop");

  // Wheel speeds stay within the saturation limit
  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (left_speed <= LIM_HI && left_speed >= LIM_LO &&
                right_speed <= LIM_HI && right_speed >= LIM_LO))
    else $error("wheel speed beyond limit");

  // Straight drive gives both wheels the same speed
  a_straight_equal: assert property (@(posedge clk) disable iff (rst)
    (!empty && drive_mode == MODE_STRAIGHT) |-> (left_speed == right_speed))
    else $error("straight mode with unequal wheel speeds");

endmodule

bind line_wall_follow_pd_drive_unit lwf_checker #(
  .SPEED_LIMIT(SPEED_LIMIT)
) u_lwf_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .left_speed (left_speed),
  .right_speed(right_speed),
  .drive_mode (drive_mode)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for line_wall_follow_pd_drive_unit: line PD, wall PD
// and straight modes under several register settings, checked per transaction.
// Depends on lwf_pkg and the unit's RTL only.
module testbench;
  import lwf_pkg::*;

  localparam int READING_W   = 10;
  localparam int SPEED_LIMIT = 10;
  localparam int SPEED_CAP   = (SPEED_LIMIT * 256 > 4095) ? 4095 : SPEED_LIMIT * 256;
  localparam int ITEMS_PER_SETTING = 175;
  localparam int LINE_WEIGHT [6] = '{3, 2, 1, -1, -2, -3};

  typedef struct packed {
    logic [READING_W-1:0] far_left;
    logic [READING_W-1:0] mid_left;
    logic [READING_W-1:0] inner_left;
    logic [READING_W-1:0] inner_right;
    logic [READING_W-1:0] mid_right;
    logic [READING_W-1:0] far_right;
    logic [READING_W-1:0] right_dist;
    logic [READING_W-1:0] left_dist;
  } sample_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
    logic [MODE_W-1:0]         mode;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [READING_W-1:0] line_far_left = '0, line_mid_left = '0, line_inner_left = '0;
  logic [READING_W-1:0] line_inner_right = '0, line_mid_right = '0, line_far_right = '0;
  logic [READING_W-1:0] right_distance = '0, left_distance = '0;
  logic signed [SPEED_W-1:0] left_speed, right_speed;
  logic [MODE_W-1:0] drive_mode;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the stored previous errors
  lwf_cfg_t cfg = '{RST_LINE_THRESHOLD, RST_WALL_TARGET, RST_WALL_NEAR_LIMIT,
                    RST_WALL_CLEAR_READING, RST_LINE_BASE_SPEED, RST_WALL_BASE_SPEED,
                    RST_LINE_P_GAIN, RST_LINE_D_GAIN};
  logic signed [SUM_W-1:0] prev_line_err = '0;
  logic signed [10:0]      prev_right_off = '0;
  logic signed [10:0]      prev_left_off = '0;

  sample_t    sensor_q [$];
  wheel_cmd_t wheel_cmd_q [$];
  sample_t    held;
  wheel_cmd_t want;
  int         send_gap = 0;
  int         pop_stall = 0;
  int         mismatches = 0;
  logic       calm = 1'b0;

  line_wall_follow_pd_drive_unit #(
    .SPEED_LIMIT(SPEED_LIMIT),
    .SENSOR_BITS(READING_W)
  ) u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .line_far_left(line_far_left), .line_mid_left(line_mid_left),
    .line_inner_left(line_inner_left), .line_inner_right(line_inner_right),
    .line_mid_right(line_mid_right), .line_far_right(line_far_right),
    .right_distance(right_distance), .left_distance(left_distance),
    .empty(empty), .pop(pop),
    .left_speed(left_speed), .right_speed(right_speed), .drive_mode(drive_mode),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Round to nearest, halves away from zero
  function automatic int nearest_div(int num, int den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic int clamp_speed(int v);
    if (v > SPEED_CAP) return SPEED_CAP;
    if (v < -SPEED_CAP) return -SPEED_CAP;
    return v;
  endfunction

  // Work out the wheel command for one sample and advance the stored errors
  function automatic wheel_cmd_t pd_drive_law(sample_t s);
    logic [READING_W-1:0] taps [6];
    int sum, n, delta, base, roff, loff, lft, rgt;
    bit seen;
    wheel_cmd_t cmd;
    taps = '{s.far_left, s.mid_left, s.inner_left, s.inner_right, s.mid_right, s.far_right};
    sum = 0;
    seen = 1'b0;
    foreach (taps[i]) begin
      if (taps[i] <= cfg.line_threshold) begin
        sum += LINE_WEIGHT[i];
        seen = 1'b1;
      end
    end
    roff = int'(s.right_dist) - int'(cfg.wall_target);
    loff = int'(s.left_dist) - int'(cfg.wall_target);
    if (seen) begin
      n = int'(cfg.line_p_gain) * sum + int'(cfg.line_d_gain) * (sum - int'(prev_line_err));
      base = int'(cfg.line_base_speed) * 256;
      delta = nearest_div(n * 128, 15);
      lft = base - delta;
      rgt = base + delta;
      cmd.mode = MODE_LINE;
    end else begin
      base = int'(cfg.wall_base_speed) * 256;
      if (s.right_dist < cfg.wall_near_limit && s.left_dist == cfg.wall_clear_reading) begin
        delta = nearest_div((2 * roff - int'(prev_right_off)) * 64, 5);
        lft = base + delta;
        rgt = base - delta;
        cmd.mode = MODE_RIGHT_WALL;
      end else if (s.right_dist == cfg.wall_clear_reading &&
                   s.left_dist < cfg.wall_near_limit) begin
        delta = nearest_div((2 * loff - int'(prev_left_off)) * 64, 5);
        lft = base - delta;
        rgt = base + delta;
        cmd.mode = MODE_LEFT_WALL;
      end else begin
        lft = base;
        rgt = base;
        cmd.mode = MODE_STRAIGHT;
      end
    end
    prev_line_err = SUM_W'(sum);
    prev_right_off = 11'(roff);
    prev_left_off = 11'(loff);
    cmd.left = SPEED_W'(clamp_speed(lft));
    cmd.right = SPEED_W'(clamp_speed(rgt));
    return cmd;
  endfunction

  function automatic sample_t mk_sample(logic [9:0] fl, logic [9:0] ml, logic [9:0] il,
                                        logic [9:0] ir, logic [9:0] mr, logic [9:0] fr,
                                        logic [9:0] rd, logic [9:0] ld);
    sample_t s;
    s = '{fl, ml, il, ir, mr, fr, rd, ld};
    return s;
  endfunction

  // Readings placed against the current threshold and wall limits
  function automatic logic [9:0] on_line();
    case ($urandom_range(0, 3))
      0: return cfg.line_threshold;
      1: return '0;
      default: return 10'($urandom_range(0, int'(cfg.line_threshold)));
    endcase
  endfunction

  function automatic logic [9:0] off_line();
    if (cfg.line_threshold == 10'h3FF) return 10'h3FF;
    case ($urandom_range(0, 3))
      0: return cfg.line_threshold + 10'd1;
      1: return 10'h3FF;
      default: return 10'($urandom_range(int'(cfg.line_threshold) + 1, 1023));
    endcase
  endfunction

  function automatic logic [9:0] near_wall();
    if (cfg.wall_near_limit == 0) return '0;
    case ($urandom_range(0, 7))
      0: return cfg.wall_near_limit - 10'd1;
      1: return '0;
      2: return cfg.wall_near_limit;
      default: return 10'($urandom_range(0, int'(cfg.wall_near_limit) - 1));
    endcase
  endfunction

  function automatic logic [9:0] side_any();
    case ($urandom_range(0, 3))
      0: return cfg.wall_clear_reading;
      1: return near_wall();
      default: return 10'($urandom);
    endcase
  endfunction

  // Mostly well-formed line and wall scenes, some straight and some noise
  function automatic sample_t gen_sample();
    logic [9:0] taps [6];
    logic [9:0] rd, ld;
    int kind;
    kind = $urandom_range(0, 9);
    foreach (taps[i]) taps[i] = off_line();
    rd = side_any();
    ld = side_any();
    case (kind)
      0, 1, 2, 3: begin
        foreach (taps[i]) taps[i] = $urandom_range(0, 1) ? on_line() : off_line();
      end
      4, 5: begin
        rd = near_wall();
        ld = ($urandom_range(0, 7) == 0) ? 10'($urandom) : cfg.wall_clear_reading;
      end
      6, 7: begin
        ld = near_wall();
        rd = ($urandom_range(0, 7) == 0) ? 10'($urandom) : cfg.wall_clear_reading;
      end
      8: ;
      default: begin
        foreach (taps[i]) taps[i] = 10'($urandom);
        rd = 10'($urandom);
        ld = 10'($urandom);
      end
    endcase
    return mk_sample(taps[0], taps[1], taps[2], taps[3], taps[4], taps[5], rd, ld);
  endfunction

  function automatic lwf_cfg_t rand_cfg();
    lwf_cfg_t c;
    c.line_threshold     = 10'($urandom_range(0, 1023));
    c.wall_target        = 10'($urandom_range(0, 1023));
    c.wall_near_limit    = 10'($urandom_range(0, 1023));
    c.wall_clear_reading = 10'($urandom_range(0, 1023));
    c.line_base_speed    = 4'($urandom_range(0, 15));
    c.wall_base_speed    = 4'($urandom_range(0, 15));
    c.line_p_gain        = 8'($urandom_range(0, 255));
    c.line_d_gain        = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Wait until nothing is queued, held or outstanding, then let the pipe drain
  task automatic settle();
    while (sensor_q.size() != 0 || push || wheel_cmd_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic apply_cfg(lwf_cfg_t c);
    write_reg(REG_LINE_THRESHOLD, c.line_threshold);
    write_reg(REG_WALL_TARGET, c.wall_target);
    write_reg(REG_WALL_NEAR_LIMIT, c.wall_near_limit);
    write_reg(REG_WALL_CLEAR_READING, c.wall_clear_reading);
    write_reg(REG_LINE_BASE_SPEED, CFG_DATA_W'(c.line_base_speed));
    write_reg(REG_WALL_BASE_SPEED, CFG_DATA_W'(c.wall_base_speed));
    write_reg(REG_LINE_P_GAIN, CFG_DATA_W'(c.line_p_gain));
    write_reg(REG_LINE_D_GAIN, CFG_DATA_W'(c.line_d_gain));
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg = c;
  endtask

  // Driver: predict on each accepted transaction, then present the next sample
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) wheel_cmd_q.push_back(pd_drive_law(held));
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (sensor_q.size() != 0) begin
          held = sensor_q.pop_front();
          line_far_left    <= held.far_left;
          line_mid_left    <= held.mid_left;
          line_inner_left  <= held.inner_left;
          line_inner_right <= held.inner_right;
          line_mid_right   <= held.mid_right;
          line_far_right   <= held.far_right;
          right_distance   <= held.right_dist;
          left_distance    <= held.left_dist;
          push <= 1'b1;
          if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (wheel_cmd_q.size() == 0) begin
          $error("result popped with no prediction waiting");
          mismatches++;
        end else begin
          want = wheel_cmd_q.pop_front();
          if (left_speed !== want.left) begin
            $error("left_speed: expected %0d, got %0d", want.left, left_speed);
            mismatches++;
          end
          if (right_speed !== want.right) begin
            $error("right_speed: expected %0d, got %0d", want.right, right_speed);
            mismatches++;
          end
          if (drive_mode !== want.mode) begin
            $error("drive_mode: expected %0d, got %0d", want.mode, drive_mode);
            mismatches++;
          end
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        pop_stall = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    lwf_cfg_t plan [$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset settings
    sensor_q.push_back(mk_sample(0, 0, 0, 0, 0, 0, 0, 0));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
    sensor_q.push_back(mk_sample(700, 701, 701, 701, 701, 701, 949, 1000));
    sensor_q.push_back(mk_sample(701, 0, 701, 701, 701, 701, 1000, 0));
    sensor_q.push_back(mk_sample(701, 701, 700, 701, 701, 701, 500, 500));
    sensor_q.push_back(mk_sample(701, 701, 701, 0, 701, 701, 1000, 1000));
    sensor_q.push_back(mk_sample(701, 701, 701, 701, 700, 701, 0, 1000));
    sensor_q.push_back(mk_sample(701, 701, 701, 701, 701, 0, 1023, 0));
    sensor_q.push_back(mk_sample(0, 0, 0, 1023, 1023, 1023, 750, 750));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 0, 0, 0, 750, 750));
    sensor_q.push_back(mk_sample(0, 1023, 1023, 1023, 1023, 0, 750, 750));
    sensor_q.push_back(mk_sample(701, 701, 701, 701, 701, 701, 949, 1000));
    sensor_q.push_back(mk_sample(701, 701, 701, 701, 701, 701, 0, 1000));
    sensor_q.push_back(mk_sample(701, 701, 701, 701, 701, 701, 950, 1000));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 1000, 0));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 1000, 949));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 1000, 950));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 1000, 1000));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 949, 999));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1000));
    sensor_q.push_back(mk_sample(1023, 1023, 1023, 1023, 1023, 1023, 751, 1000));
    sensor_q.push_back(mk_sample(10'h155, 10'h155, 10'h155, 10'h155, 10'h155, 10'h155,
                                 10'h2AA, 10'h2AA));

    // Extremes first, then random settings, then the reset values again
    plan.push_back('{10'd0, 10'd0, 10'd0, 10'd0, 4'd0, 4'd0, 8'd0, 8'd0});
    plan.push_back('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 4'd15, 4'd15, 8'd255, 8'd255});
    plan.push_back('{10'd1022, 10'd1023, 10'd1023, 10'd1023, 4'd15, 4'd15, 8'd255, 8'd0});
    plan.push_back('{10'd0, 10'd0, 10'd1023, 10'd0, 4'd0, 4'd10, 8'd0, 8'd255});
    for (int k = 0; k < 5; k++) plan.push_back(rand_cfg());
    plan.push_back('{RST_LINE_THRESHOLD, RST_WALL_TARGET, RST_WALL_NEAR_LIMIT,
                     RST_WALL_CLEAR_READING, RST_LINE_BASE_SPEED, RST_WALL_BASE_SPEED,
                     RST_LINE_P_GAIN, RST_LINE_D_GAIN});

    foreach (plan[p]) begin
      settle();
      if (p == plan.size() - 1) calm <= 1'b1;
      apply_cfg(plan[p]);
      repeat (ITEMS_PER_SETTING) sensor_q.push_back(gen_sample());
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
